// File: design/bts_pkg.sv
// Shared types, register codes and the coordinate wrap function for the texture sampler.
package bts_pkg;

    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 9;
    localparam int COORD_W = 24;
    localparam int MAX_DIM = 256;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LOADED = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                      kind;
        logic [ADDR_W-1:0]         texel_address;
        logic [7:0]                texel_red;
        logic [7:0]                texel_green;
        logic [7:0]                texel_blue;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } request_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } result_t;

    // Sizes already clamped into the legal range
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              loaded;
    } cfg_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic              kind;
        logic              black;
        logic [ADDR_W-1:0] texel_address;
        logic [23:0]       texel_rgb;
        logic [SIZE_W-1:0] x;
        logic [15:0]       xf;
        logic [SIZE_W-1:0] y;
        logic [15:0]       yf;
    } job_t;

    // Repeat wrap of a Q8.16 coordinate into 0..1.0 (Q16, 17 bits)
    function automatic logic [16:0] wrap_coord(input logic [COORD_W-1:0] raw);
        logic [COORD_W-1:0] neg;
        logic [16:0]        w;
        neg = '0 - raw;
        if (raw[COORD_W-1])
            w = 17'h10000 - {1'b0, neg[15:0]};
        else if (raw <= 24'h010000)
            w = raw[16:0];
        else
            w = {1'b0, raw[15:0]};
        return w;
    endfunction

endpackage

// File: design/bilinear_texture_sampler.sv
// Bilinear texture sampler with repeat wrap: one request per clock while full is low. A load
// request writes one RGB texel; a sample request returns one filtered 8.8 RGB result
// after the two front stages, the job queue and the back pipeline (edge tests, row offset
// multiply, registered texture store read, then the horizontal and vertical blend
// multipliers). The texture store is four copies of 65536 x 24 bits, one per
// neighbor, so all four neighbors are read in the same cycle; every load writes all copies.
// The store has no reset and no clearing pass: only written texels may be sampled.
// Configuration registers: 0 width, 1 height, 2 loaded; write them only while idle.
module bilinear_texture_sampler import bts_pkg::*; #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  request_t          request,
    output logic              empty,
    input  logic              pop,
    output result_t           result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int JOB_DEPTH = 4;
    localparam logic [SIZE_W-1:0] CLAMP_SIZE = SIZE_W'(MAX_DIM);

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic              loaded_reg;
    cfg_t              cfg;

    logic                           job_push, job_pop, job_empty;
    job_t                           job_in, job_out;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            loaded_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_LOADED: loaded_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        cfg.width  = (width_reg == '0) ? 9'd1 :
                     (width_reg > CLAMP_SIZE) ? CLAMP_SIZE : width_reg;
        cfg.height = (height_reg == '0) ? 9'd1 :
                     (height_reg > CLAMP_SIZE) ? CLAMP_SIZE : height_reg;
        cfg.loaded = loaded_reg;
    end

    bts_front #(
        .QUEUE_DEPTH (JOB_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .request     (request),
        .cfg         (cfg),
        .queue_count (job_count),
        .job_push    (job_push),
        .job         (job_in)
    );

    bts_queue #(
        .item_t (job_t),
        .DEPTH  (JOB_DEPTH)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .pop   (job_pop),
        .rdata (job_out),
        .empty (job_empty),
        .count (job_count)
    );

    bts_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .RESULT_DEPTH  (8)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .job       (job_out),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// File: design/bts_queue.sv
// Small first-in first-out queue with an occupancy count.
module bts_queue #(
    parameter type item_t = logic,
    parameter int  DEPTH  = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  item_t                      wdata,
    input  logic                       pop,
    output item_t                      rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    item_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    assign rdata = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: design/bts_front.sv
// Front end: accepts requests, wraps and scales coordinates into texel index and fraction.
module bts_front import bts_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  request_t                         request,
    input  cfg_t                             cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
    output logic                             job_push,
    output job_t                             job
);

    logic     s1_valid_reg;
    request_t s1_req_reg;
    logic     s2_valid_reg;
    job_t     s2_job_reg, s2_job_next;
    logic     accept;

    logic [16:0] u_wrap, v_wrap;
    logic [25:0] pos_u, pos_v;

    // Reserve a queue slot for every request still in the front stages
    assign full   = (int'(queue_count) + int'(s1_valid_reg) + int'(s2_valid_reg))
                    >= QUEUE_DEPTH;
    assign accept = push && !full;

    always_comb
    begin
        u_wrap = wrap_coord(s1_req_reg.coord_u);
        v_wrap = wrap_coord(s1_req_reg.coord_v);
        pos_u  = 26'(u_wrap) * 26'(cfg.width - 9'd1);
        pos_v  = 26'(v_wrap) * 26'(cfg.height - 9'd1);

        s2_job_next.kind          = s1_req_reg.kind;
        s2_job_next.black         = !cfg.loaded;
        s2_job_next.texel_address = s1_req_reg.texel_address;
        s2_job_next.texel_rgb     = {s1_req_reg.texel_red, s1_req_reg.texel_green,
                                     s1_req_reg.texel_blue};
        s2_job_next.x             = pos_u[24:16];
        s2_job_next.xf            = pos_u[15:0];
        s2_job_next.y             = pos_v[24:16];
        s2_job_next.yf            = pos_v[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= request;
        s2_job_reg <= s2_job_next;
    end

    assign job_push = s2_valid_reg;
    assign job      = s2_job_reg;

endmodule

// File: design/bts_back.sv
// Back end: neighbor addressing, texture store, bilinear blend and result queue.
module bts_back import bts_pkg::*; #(
    parameter int FRACTION_BITS = 8,
    parameter int RESULT_DEPTH  = 8
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    job_empty,
    output logic    job_pop,
    input  job_t    job,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    localparam int F    = FRACTION_BITS;
    localparam int LO_W = F + 8;
    localparam int R_W  = 2 * F + 8;
    localparam logic [F:0] ONE_W = (F+1)'(1 << F);
    localparam int RCW  = $clog2(RESULT_DEPTH + 1);

    // stage 1: edge tests
    logic              b1_valid_reg;
    job_t              b1_job_reg;
    logic              b1_xe_reg, b1_ye_reg;
    logic [SIZE_W-1:0] b1_x1_reg, b1_y1_reg;
    logic              xe_next, ye_next;

    // stage 2: row offsets, store access
    logic              b2_valid_reg;
    job_t              b2_job_reg;
    logic              b2_xe_reg, b2_ye_reg;
    logic [SIZE_W-1:0] b2_x1_reg;
    logic [17:0]       b2_yw_reg, b2_y1w_reg;
    logic [ADDR_W-1:0] rd_addr [4];
    logic              wr_en;

    // stage 3: fetched texels
    logic              b3_valid_reg;
    job_t              b3_job_reg;
    logic              b3_xe_reg, b3_ye_reg;
    logic [23:0]       rd_reg [4];

    // stage 4: horizontal blend
    logic              b4_valid_reg;
    logic              b4_black_reg;
    logic              b4_sample_reg;
    logic [F-1:0]      b4_fv_reg;
    logic [LO_W-1:0]   b4_lo_reg [3];
    logic [LO_W-1:0]   b4_hi_reg [3];
    logic [LO_W-1:0]   lo_next [3];
    logic [LO_W-1:0]   hi_next [3];

    logic              res_push;
    result_t           res_data;
    logic [RCW-1:0]    res_count;
    int                in_flight;

    assign in_flight = int'(b1_valid_reg && b1_job_reg.kind == KIND_SAMPLE)
                     + int'(b2_valid_reg && b2_job_reg.kind == KIND_SAMPLE)
                     + int'(b3_valid_reg && b3_job_reg.kind == KIND_SAMPLE)
                     + int'(b4_valid_reg && b4_sample_reg);

    // Take a request only when the result queue has room for everything in flight
    assign job_pop = !job_empty && (int'(res_count) + in_flight < RESULT_DEPTH);

    assign xe_next = ({1'b0, job.x} + 10'd1) >= {1'b0, cfg.width};
    assign ye_next = ({1'b0, job.y} + 10'd1) >= {1'b0, cfg.height};

    always_comb
    begin
        rd_addr[0] = ADDR_W'(b2_yw_reg  + 18'(b2_job_reg.x));
        rd_addr[1] = ADDR_W'(b2_y1w_reg + 18'(b2_job_reg.x));
        rd_addr[2] = ADDR_W'(b2_y1w_reg + 18'(b2_x1_reg));
        rd_addr[3] = ADDR_W'(b2_yw_reg  + 18'(b2_x1_reg));
    end

    assign wr_en = b2_valid_reg && (b2_job_reg.kind == KIND_WRITE);

    // One copy of the store per neighbor; every load writes all four
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [23:0] mem [1 << ADDR_W];
        always_ff @(posedge clk)
        begin
            if (wr_en)
                mem[b2_job_reg.texel_address] <= b2_job_reg.texel_rgb;
            rd_reg[b] <= mem[rd_addr[b]];
        end
    end

    always_comb
    begin
        logic [23:0]  t0, t1, t2, t3;
        logic [F-1:0] fu;
        logic [F:0]   wu;
        t0 = rd_reg[0];
        t1 = b3_ye_reg ? t0 : rd_reg[1];
        t2 = (b3_xe_reg || b3_ye_reg) ? t0 : rd_reg[2];
        t3 = b3_xe_reg ? t0 : rd_reg[3];
        fu = b3_job_reg.xf[15 -: F];
        wu = ONE_W - {1'b0, fu};
        for (int ch = 0; ch < 3; ch++)
        begin
            lo_next[ch] = LO_W'(t0[23-8*ch -: 8]) * LO_W'(wu)
                        + LO_W'(t3[23-8*ch -: 8]) * LO_W'(fu);
            hi_next[ch] = LO_W'(t1[23-8*ch -: 8]) * LO_W'(wu)
                        + LO_W'(t2[23-8*ch -: 8]) * LO_W'(fu);
        end
    end

    always_comb
    begin
        logic [F:0]     wv;
        logic [R_W-1:0] r [3];
        wv = ONE_W - {1'b0, b4_fv_reg};
        for (int ch = 0; ch < 3; ch++)
            r[ch] = R_W'(b4_lo_reg[ch]) * R_W'(wv) + R_W'(b4_hi_reg[ch]) * R_W'(b4_fv_reg);
        if (b4_black_reg)
        begin
            res_data = '0;
        end
        else
        begin
            res_data.out_red   = r[0][R_W-1 -: 16];
            res_data.out_green = r[1][R_W-1 -: 16];
            res_data.out_blue  = r[2][R_W-1 -: 16];
        end
    end

    assign res_push = b4_valid_reg && b4_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= job_pop;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_job_reg    <= job;
        b1_xe_reg     <= xe_next;
        b1_ye_reg     <= ye_next;
        b1_x1_reg     <= xe_next ? job.x : job.x + 9'd1;
        b1_y1_reg     <= ye_next ? job.y : job.y + 9'd1;

        b2_job_reg    <= b1_job_reg;
        b2_xe_reg     <= b1_xe_reg;
        b2_ye_reg     <= b1_ye_reg;
        b2_x1_reg     <= b1_x1_reg;
        b2_yw_reg     <= 18'(b1_job_reg.y) * 18'(cfg.width);
        b2_y1w_reg    <= 18'(b1_y1_reg) * 18'(cfg.width);

        b3_job_reg    <= b2_job_reg;
        b3_xe_reg     <= b2_xe_reg;
        b3_ye_reg     <= b2_ye_reg;

        b4_black_reg  <= b3_job_reg.black;
        b4_sample_reg <= (b3_job_reg.kind == KIND_SAMPLE);
        b4_fv_reg     <= b3_job_reg.yf[15 -: F];
        for (int ch = 0; ch < 3; ch++)
        begin
            b4_lo_reg[ch] <= lo_next[ch];
            b4_hi_reg[ch] <= hi_next[ch];
        end
    end

    bts_queue #(
        .item_t (result_t),
        .DEPTH  (RESULT_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .count (res_count)
    );

endmodule

// File: design/bts_checker.sv
// Port-level checks for the texture sampler and their binding to the top level.
module bts_checker import bts_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    push,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input result_t result
);

    // A waiting result holds until it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed or vanished while waiting");

    // Reset clears the queues
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> empty && !full)
        else $error("queues not idle after reset");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.out_red <= 16'd65280 && result.out_green <= 16'd65280
                   && result.out_blue <= 16'd65280)
        else $error("filtered color out of range");

    // Back pressure only builds from accepted requests
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted request");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
